>>> rtl/lsnt_pkg.sv
// Package: shared types, token codes and character tables of the lexical scanner.
`timescale 1ns / 1ps
package lsnt_pkg;

  // Scan mode kept between characters
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_NAME,
    MODE_ERROR
  } mode_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_NEW
  } state_e;

  // Token value source
  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_ACC,
    VSEL_HIT,
    VSEL_FILL
  } vsel_e;

  // Token kinds
  localparam logic [4:0] K_NUMBER   = 5'd0;
  localparam logic [4:0] K_IDENT    = 5'd1;
  localparam logic [4:0] K_KEYWORD0 = 5'd2;
  localparam logic [4:0] K_LBRACE   = 5'd11;
  localparam logic [4:0] K_RBRACE   = 5'd12;
  localparam logic [4:0] K_OP0      = 5'd13;
  localparam logic [4:0] K_END      = 5'd23;
  localparam logic [4:0] K_INVALID  = 5'd24;
  localparam logic [4:0] K_FULL     = 5'd25;
  localparam logic [4:0] K_TOOLONG  = 5'd26;

  localparam int         NUM_KW     = 9;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [4:0] kind;
    vsel_e      vsel;
    logic       fresh;
    logic       last;
    logic       mode_we;
    mode_e      mode;
    logic       acc_first;
    logic       acc_mac;
    logic       name_first;
    logic       name_push;
    logic       line_inc;
    logic       srch_start;
    logic       srch_adv;
    logic       append;
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic       is_digit;
    logic       is_letter;
    logic       is_space;
    logic       is_nl;
    logic       end_flag;
    logic [4:0] sym_kind;
    mode_e      mode;
    logic       slot_free;
    logic       too_long;
    logic       kw_hit;
    logic [4:0] kw_kind;
    logic       srch_more;
    logic       srch_zero;
    logic       srch_hit;
    logic       fits;
  } status_t;

  // Keyword lengths
  function automatic logic [2:0] kw_len(input logic [3:0] idx);
    case (idx)
      4'd0:    kw_len = 3'd2;
      4'd1:    kw_len = 3'd4;
      4'd2:    kw_len = 3'd5;
      4'd3:    kw_len = 3'd2;
      4'd4:    kw_len = 3'd6;
      4'd5:    kw_len = 3'd4;
      4'd6:    kw_len = 3'd5;
      4'd7:    kw_len = 3'd3;
      4'd8:    kw_len = 3'd5;
      default: kw_len = 3'd0;
    endcase
  endfunction

  // Keyword character at a position, left aligned
  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
    logic [47:0] s;
    begin
      case (idx)
        4'd0:    s = {"if", 32'h0};
        4'd1:    s = {"then", 16'h0};
        4'd2:    s = {"while", 8'h0};
        4'd3:    s = {"do", 32'h0};
        4'd4:    s = "return";
        4'd5:    s = {"read", 16'h0};
        4'd6:    s = {"print", 8'h0};
        4'd7:    s = {"int", 24'h0};
        4'd8:    s = {"const", 8'h0};
        default: s = '0;
      endcase
      case (pos)
        3'd0:    kw_char = s[47:40];
        3'd1:    kw_char = s[39:32];
        3'd2:    kw_char = s[31:24];
        3'd3:    kw_char = s[23:16];
        3'd4:    kw_char = s[15:8];
        3'd5:    kw_char = s[7:0];
        default: kw_char = 8'h00;
      endcase
    end
  endfunction

  // Kind of a single-character token, invalid when none
  function automatic logic [4:0] sym_kind(input logic [7:0] c);
    case (c)
      "{":     sym_kind = K_LBRACE;
      "}":     sym_kind = K_RBRACE;
      "(":     sym_kind = K_OP0;
      ")":     sym_kind = K_OP0 + 5'd1;
      ",":     sym_kind = K_OP0 + 5'd2;
      ";":     sym_kind = K_OP0 + 5'd3;
      "=":     sym_kind = K_OP0 + 5'd4;
      "+":     sym_kind = K_OP0 + 5'd5;
      "-":     sym_kind = K_OP0 + 5'd6;
      "*":     sym_kind = K_OP0 + 5'd7;
      "/":     sym_kind = K_OP0 + 5'd8;
      "%":     sym_kind = K_OP0 + 5'd9;
      default: sym_kind = K_INVALID;
    endcase
  endfunction

endpackage

>>> rtl/lsnt_dp.sv
// Datapath: character register, accumulators, name buffer, name table and output register.
`timescale 1ns / 1ps
module lsnt_dp import lsnt_pkg::*; #(
  parameter int TABLE_BYTES    = 512,
  parameter int MAX_NAME_CHARS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  character_i,
  input  logic        end_marker_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_value_o,
  output logic [15:0] line_number_o,
  output logic        new_name_o,
  output logic        last_of_run_o
);

  localparam int AW = $clog2(TABLE_BYTES);
  localparam int FW = $clog2(TABLE_BYTES + 1);
  localparam int SW = FW + 1;
  localparam int LW = $clog2(MAX_NAME_CHARS);

  logic [7:0]    char_q;
  logic          end_q;
  mode_e         mode_q;
  logic [31:0]   acc_q, acc_d;
  logic [LW-1:0] len_q;
  logic [FW-1:0] fill_q;
  logic [15:0]   line_q;
  logic [NUM_KW-1:0] kw_q, kw_d;
  logic [FW-1:0] sa_q, sp_q;
  logic [LW-1:0] sk_q;
  logic          sm_q;
  logic [7:0]    tab_rd_q, buf_rd_q;
  logic          ovalid_q;
  logic [4:0]    okind_q;
  logic [31:0]   ovalue_q, value_d;
  logic [15:0]   oline_q;
  logic          onew_q, olast_q;

  logic [7:0]    tab_mem [TABLE_BYTES];
  logic [7:0]    buf_mem [MAX_NAME_CHARS];

  logic [LW-1:0] pos_w;
  logic [SW-1:0] wr_sum, need_sum;
  logic          wr_ok, kw_hit;
  logic [4:0]    kw_kind;
  logic          slot_free;

  // Classify the held character
  logic is_digit, is_letter, is_space;
  assign is_digit  = (char_q >= "0") && (char_q <= "9");
  assign is_letter = ((char_q >= "a") && (char_q <= "z")) || ((char_q >= "A") && (char_q <= "Z"));
  assign is_space  = (char_q == " ") || ((char_q >= 8'd9) && (char_q <= 8'd13));

  // Table positions: next name byte, and room check for a new entry
  assign pos_w    = cmd_i.name_first ? '0 : len_q;
  assign wr_sum   = SW'(fill_q) + SW'(pos_w);
  assign wr_ok    = wr_sum < SW'(TABLE_BYTES);
  assign need_sum = SW'(fill_q) + SW'(len_q) + SW'(1);

  // Track which keywords still match the name so far
  always_comb begin
    kw_d    = kw_q;
    kw_hit  = 1'b0;
    kw_kind = K_KEYWORD0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (cmd_i.name_first) begin
        kw_d[i] = (kw_char(4'(i), 3'd0) == char_q);
      end else if (cmd_i.name_push) begin
        kw_d[i] = kw_q[i] && (LW'(kw_len(4'(i))) > len_q) &&
                  (kw_char(4'(i), len_q[2:0]) == char_q);
      end
      if (kw_q[i] && (LW'(kw_len(4'(i))) == len_q)) begin
        kw_hit  = 1'b1;
        kw_kind = K_KEYWORD0 + 5'(i);
      end
    end
  end

  // Accumulate the decimal number, times ten by shifts
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_first) begin
      acc_d = 32'(char_q - ASCII_ZERO);
    end else if (cmd_i.acc_mac) begin
      acc_d = (acc_q << 3) + (acc_q << 1) + 32'(char_q - ASCII_ZERO);
    end
  end

  // Hold the accepted character
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= character_i;
      end_q  <= end_marker_i;
    end
  end

  // Scanner control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      len_q  <= '0;
      fill_q <= '0;
      line_q <= '0;
      kw_q   <= '0;
    end else begin
      if (cmd_i.mode_we) begin
        mode_q <= cmd_i.mode;
      end
      acc_q <= acc_d;
      kw_q  <= kw_d;
      if (cmd_i.name_first) begin
        len_q <= LW'(1);
      end else if (cmd_i.name_push) begin
        len_q <= len_q + LW'(1);
      end
      if (cmd_i.append) begin
        fill_q <= FW'(need_sum);
      end
      if (cmd_i.line_inc && (line_q != 16'hFFFF)) begin
        line_q <= line_q + 16'd1;
      end
    end
  end

  // Write name bytes to the buffer and, past the fill point, to the table; append writes the zero terminator
  always_ff @(posedge clk_i) begin
    if (cmd_i.name_first || cmd_i.name_push) begin
      buf_mem[pos_w] <= char_q;
    end
    if ((cmd_i.name_first || cmd_i.name_push) && wr_ok) begin
      tab_mem[wr_sum[AW-1:0]] <= char_q;
    end else if (cmd_i.append) begin
      tab_mem[wr_sum[AW-1:0]] <= 8'h00;
    end
  end

  // Registered reads for the table walk
  always_ff @(posedge clk_i) begin
    tab_rd_q <= tab_mem[sa_q[AW-1:0]];
    buf_rd_q <= buf_mem[sk_q];
  end

  // Walk the table one byte per compare, tracking the current entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      sp_q <= '0;
      sk_q <= '0;
      sm_q <= 1'b0;
    end else if (cmd_i.srch_start) begin
      sa_q <= '0;
      sp_q <= '0;
      sk_q <= '0;
      sm_q <= 1'b1;
    end else if (cmd_i.srch_adv) begin
      sa_q <= sa_q + FW'(1);
      if (tab_rd_q == 8'h00) begin
        sp_q <= sa_q + FW'(1);
        sk_q <= '0;
        sm_q <= 1'b1;
      end else begin
        sm_q <= sm_q && (sk_q < len_q) && (buf_rd_q == tab_rd_q);
        sk_q <= sk_q + LW'(1);
      end
    end
  end

  // Select the token value
  always_comb begin
    case (cmd_i.vsel)
      VSEL_ACC:  value_d = acc_q;
      VSEL_HIT:  value_d = 32'(sp_q);
      VSEL_FILL: value_d = 32'(fill_q);
      default:   value_d = '0;
    endcase
  end

  // Output register: load on emit, drop after transfer
  assign slot_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      okind_q  <= cmd_i.kind;
      ovalue_q <= value_d;
      oline_q  <= line_q;
      onew_q   <= cmd_i.fresh;
      olast_q  <= cmd_i.last;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign token_kind_o  = okind_q;
  assign token_value_o = ovalue_q;
  assign line_number_o = oline_q;
  assign new_name_o    = onew_q;
  assign last_of_run_o = olast_q;

  // Status to the controller
  always_comb begin
    status_o.is_digit  = is_digit;
    status_o.is_letter = is_letter;
    status_o.is_space  = is_space;
    status_o.is_nl     = (char_q == 8'd10);
    status_o.end_flag  = end_q;
    status_o.sym_kind  = sym_kind(char_q);
    status_o.mode      = mode_q;
    status_o.slot_free = slot_free;
    status_o.too_long  = len_q >= LW'(MAX_NAME_CHARS - 1);
    status_o.kw_hit    = kw_hit;
    status_o.kw_kind   = kw_kind;
    status_o.srch_more = sa_q < fill_q;
    status_o.srch_zero = (tab_rd_q == 8'h00);
    status_o.srch_hit  = sm_q && (sk_q == len_q);
    status_o.fits      = need_sum <= SW'(TABLE_BYTES);
  end

endmodule

>>> rtl/lsnt_ctrl.sv
// Controller: sequences each character through evaluation, table walk and token transfers.
`timescale 1ns / 1ps
module lsnt_ctrl import lsnt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   sc_emit;
  logic   last2;

  // Scanning the character from idle mode emits only for symbols and errors
  assign sc_emit = !(st_i.is_space || st_i.is_digit || st_i.is_letter);
  // Last flag of a pending token that the character ends
  assign last2   = !st_i.end_flag && !sc_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (st_i.end_flag) begin
          case (st_i.mode)
            MODE_NUMBER: state_d = st_i.slot_free ? ST_SCAN : ST_EVAL;
            MODE_NAME: begin
              if (st_i.kw_hit) state_d = st_i.slot_free ? ST_SCAN : ST_EVAL;
              else state_d = ST_SRCH_RD;
            end
            default: state_d = ST_SCAN;
          endcase
        end else begin
          case (st_i.mode)
            MODE_IDLE: state_d = (sc_emit && !st_i.slot_free) ? ST_EVAL : ST_IDLE;
            MODE_NUMBER: begin
              if (st_i.is_digit) state_d = ST_IDLE;
              else state_d = st_i.slot_free ? ST_SCAN : ST_EVAL;
            end
            MODE_NAME: begin
              if (st_i.is_digit || st_i.is_letter) begin
                state_d = (st_i.too_long && !st_i.slot_free) ? ST_EVAL : ST_IDLE;
              end else if (st_i.kw_hit) begin
                state_d = st_i.slot_free ? ST_SCAN : ST_EVAL;
              end else begin
                state_d = ST_SRCH_RD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (st_i.end_flag) state_d = st_i.slot_free ? ST_IDLE : ST_SCAN;
        else if (st_i.mode == MODE_ERROR) state_d = ST_IDLE;
        else state_d = (sc_emit && !st_i.slot_free) ? ST_SCAN : ST_IDLE;
      end
      ST_SRCH_RD: begin
        state_d = st_i.srch_more ? ST_SRCH_CMP : ST_NEW;
      end
      ST_SRCH_CMP: begin
        if (st_i.srch_zero && st_i.srch_hit) state_d = st_i.slot_free ? ST_SCAN : ST_SRCH_CMP;
        else state_d = ST_SRCH_RD;
      end
      ST_NEW: begin
        state_d = st_i.slot_free ? ST_SCAN : ST_NEW;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.vsel = VSEL_ZERO;
    cmd_o.mode = MODE_IDLE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        if (st_i.end_flag) begin
          if (st_i.mode == MODE_NUMBER && st_i.slot_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = K_NUMBER;
            cmd_o.vsel    = VSEL_ACC;
            cmd_o.mode_we = 1'b1;
          end else if (st_i.mode == MODE_NAME) begin
            if (!st_i.kw_hit) begin
              cmd_o.srch_start = 1'b1;
            end else if (st_i.slot_free) begin
              cmd_o.emit    = 1'b1;
              cmd_o.kind    = st_i.kw_kind;
              cmd_o.mode_we = 1'b1;
            end
          end
        end else begin
          case (st_i.mode)
            MODE_IDLE: begin
              // Scan the character directly
              if (st_i.is_space) begin
                cmd_o.line_inc = st_i.is_nl;
              end else if (st_i.is_digit) begin
                cmd_o.acc_first = 1'b1;
                cmd_o.mode_we   = 1'b1;
                cmd_o.mode      = MODE_NUMBER;
              end else if (st_i.is_letter) begin
                cmd_o.name_first = 1'b1;
                cmd_o.mode_we    = 1'b1;
                cmd_o.mode       = MODE_NAME;
              end else if (st_i.slot_free) begin
                cmd_o.emit    = 1'b1;
                cmd_o.kind    = st_i.sym_kind;
                cmd_o.last    = 1'b1;
                cmd_o.mode_we = (st_i.sym_kind == K_INVALID);
                cmd_o.mode    = MODE_ERROR;
              end
            end
            MODE_NUMBER: begin
              if (st_i.is_digit) begin
                cmd_o.acc_mac = 1'b1;
              end else if (st_i.slot_free) begin
                cmd_o.emit    = 1'b1;
                cmd_o.kind    = K_NUMBER;
                cmd_o.vsel    = VSEL_ACC;
                cmd_o.last    = last2;
                cmd_o.mode_we = 1'b1;
              end
            end
            MODE_NAME: begin
              if (st_i.is_digit || st_i.is_letter) begin
                if (!st_i.too_long) begin
                  cmd_o.name_push = 1'b1;
                end else if (st_i.slot_free) begin
                  cmd_o.emit    = 1'b1;
                  cmd_o.kind    = K_TOOLONG;
                  cmd_o.last    = 1'b1;
                  cmd_o.mode_we = 1'b1;
                  cmd_o.mode    = MODE_ERROR;
                end
              end else if (!st_i.kw_hit) begin
                cmd_o.srch_start = 1'b1;
              end else if (st_i.slot_free) begin
                cmd_o.emit    = 1'b1;
                cmd_o.kind    = st_i.kw_kind;
                cmd_o.last    = last2;
                cmd_o.mode_we = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (st_i.end_flag) begin
          if (st_i.slot_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = K_END;
            cmd_o.last    = 1'b1;
            cmd_o.mode_we = 1'b1;
          end
        end else if (st_i.mode != MODE_ERROR) begin
          if (st_i.is_space) begin
            cmd_o.line_inc = st_i.is_nl;
          end else if (st_i.is_digit) begin
            cmd_o.acc_first = 1'b1;
            cmd_o.mode_we   = 1'b1;
            cmd_o.mode      = MODE_NUMBER;
          end else if (st_i.is_letter) begin
            cmd_o.name_first = 1'b1;
            cmd_o.mode_we    = 1'b1;
            cmd_o.mode       = MODE_NAME;
          end else if (st_i.slot_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = st_i.sym_kind;
            cmd_o.last    = 1'b1;
            cmd_o.mode_we = (st_i.sym_kind == K_INVALID);
            cmd_o.mode    = MODE_ERROR;
          end
        end
      end
      ST_SRCH_CMP: begin
        if (!(st_i.srch_zero && st_i.srch_hit)) begin
          cmd_o.srch_adv = 1'b1;
        end else if (st_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = K_IDENT;
          cmd_o.vsel    = VSEL_HIT;
          cmd_o.last    = last2;
          cmd_o.mode_we = 1'b1;
        end
      end
      ST_NEW: begin
        if (st_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.mode_we = 1'b1;
          if (st_i.fits) begin
            cmd_o.kind   = K_IDENT;
            cmd_o.vsel   = VSEL_FILL;
            cmd_o.fresh  = 1'b1;
            cmd_o.last   = last2;
            cmd_o.append = 1'b1;
          end else begin
            cmd_o.kind = K_FULL;
            cmd_o.last = !st_i.end_flag;
            cmd_o.mode = MODE_ERROR;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/lexical_scanner_with_name_table.sv
// Top level: lexical scanner with a byte-packed name table.
//
//   Channel  Signals                                          Direction
//   in       in_valid_i/in_ready_o, character_i, end_marker_i  into block
//   out      out_valid_o/out_ready_i, token_kind_o,            out of block
//            token_value_o, line_number_o, new_name_o, last_of_run_o
//
// A character passes through accept and evaluate; one that ends a pending token
// and is itself scanned also passes through a scan step. Finishing an identifier
// walks the name table through its single read port, reading then comparing each stored byte.
// Input is taken one item at a time; ready stays low while an item is at work.
// A full output register stalls the controller until the token transfers.
// Reset clears control state at once; the tables need no clearing pass.
`timescale 1ns / 1ps
module lexical_scanner_with_name_table import lsnt_pkg::*; #(
  parameter int TABLE_BYTES    = 512,
  parameter int MAX_NAME_CHARS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        end_marker_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_value_o,
  output logic [15:0] line_number_o,
  output logic        new_name_o,
  output logic        last_of_run_o
);

  cmd_t    cmd;
  status_t status;

  // Sequence each character
  lsnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (status),
    .cmd_o      (cmd)
  );

  // Hold scanner state, tables and the output register
  lsnt_dp #(
    .TABLE_BYTES    (TABLE_BYTES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .character_i   (character_i),
    .end_marker_i  (end_marker_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .line_number_o (line_number_o),
    .new_name_o    (new_name_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
